// ===== hw/rtl/tapmm_pkg.sv =====
`timescale 1ns / 1ps

package tapmm_pkg;

	// field and datapath widths
	localparam int unsigned DATA_W  = 16;
	localparam int unsigned DIFF_W  = DATA_W + 1;
	localparam int unsigned INTEG_W = 32;
	localparam int unsigned PROD_W  = 2 * DIFF_W;
	localparam int unsigned PRODI_W = DIFF_W + INTEG_W;
	localparam int unsigned SUM_W   = PRODI_W + 1;
	localparam int unsigned DRIVE_W = 32;
	localparam int unsigned MIX_W   = DRIVE_W + 2;
	localparam int unsigned WIDTH_W = 13;
	localparam int unsigned OUT_SHIFT = 18;

	// motor pulse width base and limits
	localparam logic [WIDTH_W-1:0] WIDTH_BASE = 13'd4800;
	localparam logic [WIDTH_W-1:0] WIDTH_MIN  = 13'd2400;
	localparam logic [WIDTH_W-1:0] WIDTH_MAX  = 13'd6400;

	// removes the fixed rate offset of -1.00
	localparam logic signed [DIFF_W-1:0] RATE_BIAS = 17'sd64;

	// register reset values
	localparam logic [DATA_W-1:0] GAIN_P_RST = 16'd11469;
	localparam logic [DATA_W-1:0] GAIN_I_RST = 16'd205;
	localparam logic [DATA_W-1:0] GAIN_D_RST = 16'd5530;
	localparam logic [DATA_W-1:0] TARGET_RST = 16'hFFF1;

	// register map, one word each
	localparam int unsigned REG_IDX_W = 3;
	localparam int unsigned ADDR_W    = REG_IDX_W + 2;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_GAIN_P_X   = 3'd0,
		REG_GAIN_I_X   = 3'd1,
		REG_GAIN_D_X   = 3'd2,
		REG_GAIN_P_Y   = 3'd3,
		REG_GAIN_I_Y   = 3'd4,
		REG_GAIN_D_Y   = 3'd5,
		REG_TARGET_X   = 3'd6,
		REG_TARGET_Y   = 3'd7
	} reg_idx_t;

endpackage

// ===== hw/rtl/two_axis_pid_motor_mixer_core.sv =====
`timescale 1ns / 1ps

// Two-axis PID attitude controller with a four-motor mixer. Each item carries
// roll (x) and pitch (y) angles and rates at 1/64 unit per step; per axis the
// block forms the error against the target angle, updates a saturating 32-bit
// integral, computes u = (Kp*e + Ki*sum - Kd*(rate+64)) >> 18 with Q4.12 gains
// (floor rounding) and drives widths 4800 -/+ u clamped to 2400..6400. One item
// is taken per cycle unless in_stall is high; a result passes the error and
// integral stage, multiply stage, sum stage and mix register; the rate is set
// by the integral update in the first stage. Empty stages keep filling while
// a result waits on a stalled output. Gains and targets sit in APB registers
// at byte addresses 4*i, to be written only idle; the block does not check.

module two_axis_pid_motor_mixer_core
	import tapmm_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	// configuration port
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [ADDR_W-1:0]         paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	// input items
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic signed [DATA_W-1:0]  angle_x,
	input  logic signed [DATA_W-1:0]  angle_y,
	input  logic signed [DATA_W-1:0]  rate_x,
	input  logic signed [DATA_W-1:0]  rate_y,
	// result items
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [WIDTH_W-1:0]        width_0,
	output logic [WIDTH_W-1:0]        width_1,
	output logic [WIDTH_W-1:0]        width_2,
	output logic [WIDTH_W-1:0]        width_3
);

	// saturating add of the error into the integral
	function automatic logic signed [INTEG_W-1:0] sat_add(
		input logic signed [INTEG_W-1:0] acc,
		input logic signed [DIFF_W-1:0]  inc
	);
		logic signed [INTEG_W:0] t;
		t = {acc[INTEG_W-1], acc} + {{(INTEG_W-DIFF_W+1){inc[DIFF_W-1]}}, inc};
		if (t[INTEG_W] != t[INTEG_W-1]) begin
			return t[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}} : {1'b0, {(INTEG_W-1){1'b1}}};
		end
		return t[INTEG_W-1:0];
	endfunction

	// clamp a mixed width to the allowed pulse range
	function automatic logic [WIDTH_W-1:0] clamp_width(input logic signed [MIX_W-1:0] m);
		logic signed [MIX_W-1:0] lo;
		logic signed [MIX_W-1:0] hi;
		lo = signed'(MIX_W'(WIDTH_MIN));
		hi = signed'(MIX_W'(WIDTH_MAX));
		if (m > hi) begin
			return WIDTH_MAX;
		end
		if (m < lo) begin
			return WIDTH_MIN;
		end
		return m[WIDTH_W-1:0];
	endfunction

	logic [DATA_W-1:0] gain_p_x_q, gain_i_x_q, gain_d_x_q;
	logic [DATA_W-1:0] gain_p_y_q, gain_i_y_q, gain_d_y_q;
	logic [DATA_W-1:0] target_x_q, target_y_q;

	logic                      cfg_wr;
	reg_idx_t                  cfg_idx;

	// configuration writes
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_x_q <= GAIN_P_RST;
			gain_i_x_q <= GAIN_I_RST;
			gain_d_x_q <= GAIN_D_RST;
			gain_p_y_q <= GAIN_P_RST;
			gain_i_y_q <= GAIN_I_RST;
			gain_d_y_q <= GAIN_D_RST;
			target_x_q <= TARGET_RST;
			target_y_q <= TARGET_RST;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_GAIN_P_X: gain_p_x_q <= pwdata[DATA_W-1:0];
				REG_GAIN_I_X: gain_i_x_q <= pwdata[DATA_W-1:0];
				REG_GAIN_D_X: gain_d_x_q <= pwdata[DATA_W-1:0];
				REG_GAIN_P_Y: gain_p_y_q <= pwdata[DATA_W-1:0];
				REG_GAIN_I_Y: gain_i_y_q <= pwdata[DATA_W-1:0];
				REG_GAIN_D_Y: gain_d_y_q <= pwdata[DATA_W-1:0];
				REG_TARGET_X: target_x_q <= pwdata[DATA_W-1:0];
				REG_TARGET_Y: target_y_q <= pwdata[DATA_W-1:0];
				default: ;
			endcase
		end
	end

	// register readback, targets sign extended
	always_comb begin
		unique case (cfg_idx)
			REG_GAIN_P_X: prdata = {16'd0, gain_p_x_q};
			REG_GAIN_I_X: prdata = {16'd0, gain_i_x_q};
			REG_GAIN_D_X: prdata = {16'd0, gain_d_x_q};
			REG_GAIN_P_Y: prdata = {16'd0, gain_p_y_q};
			REG_GAIN_I_Y: prdata = {16'd0, gain_i_y_q};
			REG_GAIN_D_Y: prdata = {16'd0, gain_d_y_q};
			REG_TARGET_X: prdata = {{16{target_x_q[DATA_W-1]}}, target_x_q};
			REG_TARGET_Y: prdata = {{16{target_y_q[DATA_W-1]}}, target_y_q};
			default:      prdata = 32'd0;
		endcase
	end

	// stage flow control, a stage loads when empty or when it moves on
	logic v_s1, v_s2, v_s3;
	logic rdy_out, rdy_s3, rdy_s2, rdy_s1;
	logic in_acc;

	assign rdy_out  = !out_valid || !out_stall;
	assign rdy_s3   = !v_s3 || rdy_out;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_stall = !rdy_s1;
	assign in_acc   = in_valid && !in_stall;

	// stage 1: error, rate with offset removed, integral update
	logic signed [DIFF_W-1:0]  e_x, e_y, w_x, w_y;
	logic signed [INTEG_W-1:0] integ_x_q, integ_y_q;
	logic signed [INTEG_W-1:0] integ_x_nxt, integ_y_nxt;

	assign e_x = signed'({target_x_q[DATA_W-1], target_x_q}) - {angle_x[DATA_W-1], angle_x};
	assign e_y = signed'({target_y_q[DATA_W-1], target_y_q}) - {angle_y[DATA_W-1], angle_y};
	assign w_x = {rate_x[DATA_W-1], rate_x} + RATE_BIAS;
	assign w_y = {rate_y[DATA_W-1], rate_y} + RATE_BIAS;
	assign integ_x_nxt = sat_add(integ_x_q, e_x);
	assign integ_y_nxt = sat_add(integ_y_q, e_y);

	logic signed [DIFF_W-1:0]  e_x_s1, e_y_s1, w_x_s1, w_y_s1;
	logic signed [INTEG_W-1:0] s_x_s1, s_y_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_x_q <= '0;
			integ_y_q <= '0;
		end else if (in_acc) begin
			integ_x_q <= integ_x_nxt;
			integ_y_q <= integ_y_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			e_x_s1 <= e_x;
			e_y_s1 <= e_y;
			w_x_s1 <= w_x;
			w_y_s1 <= w_y;
			s_x_s1 <= integ_x_nxt;
			s_y_s1 <= integ_y_nxt;
		end
	end

	// stage 2: gain products
	logic signed [PROD_W-1:0]  pp_x_s2, pd_x_s2, pp_y_s2, pd_y_s2;
	logic signed [PRODI_W-1:0] pi_x_s2, pi_y_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			pp_x_s2 <= signed'({1'b0, gain_p_x_q}) * e_x_s1;
			pi_x_s2 <= signed'({1'b0, gain_i_x_q}) * s_x_s1;
			pd_x_s2 <= signed'({1'b0, gain_d_x_q}) * w_x_s1;
			pp_y_s2 <= signed'({1'b0, gain_p_y_q}) * e_y_s1;
			pi_y_s2 <= signed'({1'b0, gain_i_y_q}) * s_y_s1;
			pd_y_s2 <= signed'({1'b0, gain_d_y_q}) * w_y_s1;
		end
	end

	// stage 3: sum and scale, arithmetic shift rounds toward minus infinity
	logic signed [SUM_W-1:0]   sum_x, sum_y;
	logic signed [DRIVE_W-1:0] u_x_s3, u_y_s3;

	assign sum_x = SUM_W'(pp_x_s2) + SUM_W'(pi_x_s2) - SUM_W'(pd_x_s2);
	assign sum_y = SUM_W'(pp_y_s2) + SUM_W'(pi_y_s2) - SUM_W'(pd_y_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && v_s2) begin
			u_x_s3 <= sum_x[OUT_SHIFT +: DRIVE_W];
			u_y_s3 <= sum_y[OUT_SHIFT +: DRIVE_W];
		end
	end

	// mix into motor widths and clamp
	logic signed [MIX_W-1:0] base_m, ux_m, uy_m;

	assign base_m = signed'(MIX_W'(WIDTH_BASE));
	assign ux_m   = {{(MIX_W-DRIVE_W){u_x_s3[DRIVE_W-1]}}, u_x_s3};
	assign uy_m   = {{(MIX_W-DRIVE_W){u_y_s3[DRIVE_W-1]}}, u_y_s3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (rdy_out) begin
			out_valid <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_out && v_s3) begin
			width_0 <= clamp_width(base_m - uy_m);
			width_1 <= clamp_width(base_m - ux_m);
			width_2 <= clamp_width(base_m + uy_m);
			width_3 <= clamp_width(base_m + ux_m);
		end
	end

	// checks
	a_width_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (width_0 >= WIDTH_MIN) && (width_0 <= WIDTH_MAX) &&
			(width_3 >= WIDTH_MIN) && (width_3 <= WIDTH_MAX))
		else $error("motor width outside pulse range");

	a_integ_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!in_acc |=> $stable(integ_x_q) && $stable(integ_y_q))
		else $error("integral changed without an accepted item");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> v_s1 && v_s2 && v_s3 && out_valid && out_stall)
		else $error("input stalled while a stage is free");

	a_stage_move: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && rdy_out) |=> out_valid)
		else $error("item lost between sum stage and output");

endmodule

// ===== tb/tb_two_axis_pid_motor_mixer_core.sv =====
`timescale 1ns / 1ps

module tb_two_axis_pid_motor_mixer_core;
	import tapmm_pkg::*;

	typedef logic [3:0][WIDTH_W-1:0] widths_t;

	localparam longint INTEG_HI = 64'sd2147483647;
	localparam longint INTEG_LO = -64'sd2147483648;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [DATA_W-1:0] angle_x = '0;
	logic signed [DATA_W-1:0] angle_y = '0;
	logic signed [DATA_W-1:0] rate_x = '0;
	logic signed [DATA_W-1:0] rate_y = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [WIDTH_W-1:0] width_0;
	logic [WIDTH_W-1:0] width_1;
	logic [WIDTH_W-1:0] width_2;
	logic [WIDTH_W-1:0] width_3;

	// shadow of the gain and target registers plus the two integrals
	logic [DATA_W-1:0] reg_shadow [8];
	longint integ_x;
	longint integ_y;

	widths_t pending_widths [$];
	int mismatch_count = 0;
	int items_sent = 0;
	int results_checked = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	two_axis_pid_motor_mixer_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.angle_x   (angle_x),
		.angle_y   (angle_y),
		.rate_x    (rate_x),
		.rate_y    (rate_y),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.width_0   (width_0),
		.width_1   (width_1),
		.width_2   (width_2),
		.width_3   (width_3)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// random receiver stall
	always @(posedge clk) begin
		out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
	end

	// saturating integral update
	function automatic longint integ_next(longint integ, longint err);
		longint s;
		s = integ + err;
		if (s > INTEG_HI)
			s = INTEG_HI;
		if (s < INTEG_LO)
			s = INTEG_LO;
		return s;
	endfunction

	// pid drive of one axis, arithmetic shift rounds toward minus infinity
	function automatic longint axis_drive(longint kp, longint ki, longint kd, longint err,
			longint integ, longint rate);
		longint acc;
		acc = kp * err + ki * integ - kd * (rate + longint'(RATE_BIAS));
		return acc >>> OUT_SHIFT;
	endfunction

	function automatic logic [WIDTH_W-1:0] clamp_width(longint v);
		if (v > longint'(WIDTH_MAX))
			return WIDTH_MAX;
		if (v < longint'(WIDTH_MIN))
			return WIDTH_MIN;
		return v[WIDTH_W-1:0];
	endfunction

	// expected motor widths for one accepted item, updates the integrals
	task automatic predict_widths(input logic signed [DATA_W-1:0] ax, ay, rx, ry);
		longint ex;
		longint ey;
		longint ux;
		longint uy;
		widths_t w;
		ex = longint'($signed(reg_shadow[REG_TARGET_X])) - longint'(ax);
		ey = longint'($signed(reg_shadow[REG_TARGET_Y])) - longint'(ay);
		integ_x = integ_next(integ_x, ex);
		integ_y = integ_next(integ_y, ey);
		ux = axis_drive(longint'(reg_shadow[REG_GAIN_P_X]), longint'(reg_shadow[REG_GAIN_I_X]),
			longint'(reg_shadow[REG_GAIN_D_X]), ex, integ_x, longint'(rx));
		uy = axis_drive(longint'(reg_shadow[REG_GAIN_P_Y]), longint'(reg_shadow[REG_GAIN_I_Y]),
			longint'(reg_shadow[REG_GAIN_D_Y]), ey, integ_y, longint'(ry));
		w[0] = clamp_width(longint'(WIDTH_BASE) - uy);
		w[1] = clamp_width(longint'(WIDTH_BASE) - ux);
		w[2] = clamp_width(longint'(WIDTH_BASE) + uy);
		w[3] = clamp_width(longint'(WIDTH_BASE) + ux);
		pending_widths.push_back(w);
	endtask

	// result checker
	always @(posedge clk) begin : check_results
		widths_t got;
		widths_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = {width_3, width_2, width_1, width_0};
			if (pending_widths.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected result, expected none, got %0d %0d %0d %0d",
					$time, got[0], got[1], got[2], got[3]);
			end else begin
				want = pending_widths.pop_front();
				results_checked++;
				for (int i = 0; i < 4; i++) begin
					if (got[i] !== want[i]) begin
						mismatch_count++;
						$display("%0t: width_%0d expected %0d, got %0d",
							$time, i, want[i], got[i]);
					end
				end
			end
		end
	end

	task automatic set_idling(input int send_pct, input int recv_pct);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
	endtask

	// send one item, predict on acceptance, then maybe idle
	task automatic send_sample(input logic signed [DATA_W-1:0] ax, ay, rx, ry);
		in_valid <= 1'b1;
		angle_x <= ax;
		angle_y <= ay;
		rate_x <= rx;
		rate_y <= ry;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		predict_widths(ax, ay, rx, ry);
		items_sent++;
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
	endtask

	// stop sending and wait until every result is out of the pipeline
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_widths.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic reg_write(input reg_idx_t idx, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (pready !== 1'b1);
		reg_shadow[idx] = data[DATA_W-1:0];
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic reg_read_check(input reg_idx_t idx);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (pready !== 1'b1);
		if (prdata[DATA_W-1:0] !== reg_shadow[idx]) begin
			mismatch_count++;
			$display("%0t: register %s expected %h, got %h",
				$time, idx.name(), reg_shadow[idx], prdata[DATA_W-1:0]);
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_axis_gains(input logic [31:0] kp, ki, kd);
		reg_write(REG_GAIN_P_X, kp);
		reg_write(REG_GAIN_I_X, ki);
		reg_write(REG_GAIN_D_X, kd);
		reg_write(REG_GAIN_P_Y, kp);
		reg_write(REG_GAIN_I_Y, ki);
		reg_write(REG_GAIN_D_Y, kd);
	endtask

	// reset values read back, then one item at zero and one at target with rate offset removed
	task automatic test_reset_values();
		for (int r = 0; r < 8; r++)
			reg_read_check(reg_idx_t'(r));
		send_sample(16'sd0, 16'sd0, 16'sd0, 16'sd0);
		send_sample(-16'sd15, -16'sd15, -16'sd64, -16'sd64);
		wait_idle();
	endtask

	// every register written with junk in the upper bits, then read back
	task automatic test_register_access();
		logic [31:0] data;
		for (int r = 0; r < 8; r++) begin
			data = {16'hA5C3 ^ 16'(r), 16'($urandom_range(0, 20000))};
			reg_write(reg_idx_t'(r), data);
			reg_read_check(reg_idx_t'(r));
		end
	endtask

	// extremes and alternating bit patterns of every input field
	task automatic test_field_extremes();
		send_sample(-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767);
		send_sample(16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768);
		send_sample(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
		send_sample(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
		send_sample(16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA);
		send_sample(16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555);
		wait_idle();
	endtask

	// unity proportional gain, u = floor(e / 64) checks rounding toward minus infinity
	task automatic test_rounding();
		set_axis_gains(32'd4096, 32'd0, 32'd0);
		reg_write(REG_TARGET_X, 32'd0);
		reg_write(REG_TARGET_Y, 32'd0);
		send_sample(16'sd1, -16'sd1, 16'sd100, -16'sd100);
		send_sample(16'sd64, -16'sd64, 16'sd0, 16'sd0);
		send_sample(16'sd65, -16'sd65, -16'sd64, 16'sd64);
		send_sample(-16'sd63, 16'sd63, 16'sd1, -16'sd1);
		send_sample(-16'sd64, 16'sd64, 16'sd7, -16'sd7);
		wait_idle();
	endtask

	// drives just inside and just beyond the clamp limits
	task automatic test_clamp_limits();
		set_axis_gains(32'd65535, 32'd0, 32'd0);
		send_sample(-16'sd6400, 16'sd6400, 16'sd3, -16'sd3);
		send_sample(-16'sd6401, 16'sd6401, 16'sd0, 16'sd0);
		send_sample(16'sd6404, -16'sd6405, 16'sd0, 16'sd0);
		send_sample(16'sd6408, -16'sd6408, -16'sd9, 16'sd9);
		wait_idle();
	endtask

	// three phases, each with its own register setting and idling mode
	task automatic test_random();
		logic [31:0] data;
		logic signed [DATA_W-1:0] ax;
		logic signed [DATA_W-1:0] ay;
		logic signed [DATA_W-1:0] rx;
		logic signed [DATA_W-1:0] ry;
		int tx;
		int ty;
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: set_idling(28, 48);
				1: set_idling(48, 28);
				default: set_idling(0, 0);
			endcase
			for (int r = 0; r < 8; r++) begin
				if (phase == 0) begin
					data = (r < 6) ? $urandom_range(0, 16383) : 32'($urandom_range(0, 511) - 256);
				end else if (phase == 1) begin
					data = $urandom;
				end else begin
					data = {16'($urandom_range(0, 65535)),
						($urandom_range(1) ? 16'hFFFF : 16'h0000)};
					if (r >= 6)
						data[15:0] = $urandom_range(1) ? 16'h7FFF : 16'h8000;
				end
				reg_write(reg_idx_t'(r), data);
			end
			tx = $signed(reg_shadow[REG_TARGET_X]);
			ty = $signed(reg_shadow[REG_TARGET_Y]);
			for (int n = 0; n < 170; n++) begin
				if ($urandom_range(99) < 70) begin
					// well-behaved flight: angles near the target, modest rates
					ax = 16'(tx + $urandom_range(0, 512) - 256);
					ay = 16'(ty + $urandom_range(0, 512) - 256);
					rx = 16'($urandom_range(0, 2048) - 1024);
					ry = 16'($urandom_range(0, 2048) - 1024);
				end else begin
					ax = 16'($urandom);
					ay = 16'($urandom);
					rx = 16'($urandom);
					ry = 16'($urandom);
				end
				send_sample(ax, ay, rx, ry);
			end
			wait_idle();
		end
	endtask

	// full-scale error winds each integral one way, back through zero to the other
	// sign and home again; a small integral gain keeps the drive readable
	task automatic test_integral_windup();
		set_idling(0, 0);
		set_axis_gains(32'd0, 32'd64, 32'd0);
		for (int leg = 0; leg < 3; leg++) begin
			reg_write(REG_TARGET_X, (leg == 1) ? 32'h8000 : 32'h7FFF);
			reg_write(REG_TARGET_Y, (leg == 1) ? 32'h7FFF : 32'h8000);
			for (int n = 0; n < ((leg == 1) ? 80 : 40); n++) begin
				if (leg == 1)
					send_sample(16'sd32767, -16'sd32768, 16'($urandom), 16'($urandom));
				else
					send_sample(-16'sd32768, 16'sd32767, 16'($urandom), 16'($urandom));
			end
			wait_idle();
		end
	endtask

	initial begin
		reg_shadow[REG_GAIN_P_X] = GAIN_P_RST;
		reg_shadow[REG_GAIN_I_X] = GAIN_I_RST;
		reg_shadow[REG_GAIN_D_X] = GAIN_D_RST;
		reg_shadow[REG_GAIN_P_Y] = GAIN_P_RST;
		reg_shadow[REG_GAIN_I_Y] = GAIN_I_RST;
		reg_shadow[REG_GAIN_D_Y] = GAIN_D_RST;
		reg_shadow[REG_TARGET_X] = TARGET_RST;
		reg_shadow[REG_TARGET_Y] = TARGET_RST;
		integ_x = 0;
		integ_y = 0;
		set_idling(28, 48);
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_register_access();
		test_field_extremes();
		test_rounding();
		test_clamp_limits();
		test_random();
		test_integral_windup();

		$display("%0d items sent, %0d results compared", items_sent, results_checked);
		$display("covered reset values, register access, field extremes, rounding, clamp");
		$display("limits, random traffic in three idling modes and integral windup");
		if (mismatch_count == 0)
			$display("two_axis_pid_motor_mixer_core test passed");
		else
			$display("two_axis_pid_motor_mixer_core test failed");
		$finish;
	end

	// watchdog
	initial begin
		#10_000_000;
		$display("two_axis_pid_motor_mixer_core test failed");
		$finish;
	end

endmodule
